/* rtl/core/dual_polynomial_string_hash_core_defines.svh */
// assertion macros shared by the dual polynomial string hash core
// no dependencies; included by the modules that carry assertions
`ifndef DUAL_POLYNOMIAL_STRING_HASH_CORE_DEFINES_SVH
`define DUAL_POLYNOMIAL_STRING_HASH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define DPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dph assertion failed");

// next-cycle implication, disabled while in reset
`define DPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dph assertion failed");

`else

`define DPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DPH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/dph_pkg.sv */
// shared types, constants and helper functions of the dual polynomial string hash core
// no dependencies; imported by every module of the core
package dph_pkg;

    // input character and accumulator sizing
    localparam int CHAR_W     = 16;
    localparam int ACC_W      = 32;
    localparam int MAX_CHARS  = 128;
    localparam int COUNT_W    = 8;

    // combined hash layout
    localparam int HASH_SHIFT = 9;
    localparam int TOP_SHIFT  = 23;
    localparam int TOP_W      = ACC_W - TOP_SHIFT;
    localparam int HASH_W     = ACC_W + HASH_SHIFT;

    // base-36 text formatting
    localparam int RADIX           = 36;
    localparam int HALF_RADIX      = RADIX / 2;
    localparam int NUM_DIGITS      = 8;
    localparam int DIGIT_W         = 6;
    localparam int TEXT_W          = 7;
    localparam int ASCII_ZERO      = 48;
    localparam int ASCII_ALPHA_OFS = 55;
    localparam int DECIMAL_DIGITS  = 10;

    // shift-and-double conversion pipeline
    localparam int STEPS_PER_STAGE = 7;
    localparam int NUM_STAGES      = 6;
    localparam int REM_W           = NUM_STAGES * STEPS_PER_STAGE;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;

    // input beat
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              last;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [TEXT_W-1:0] text_0;
        logic [TEXT_W-1:0] text_1;
        logic [TEXT_W-1:0] text_2;
        logic [TEXT_W-1:0] text_3;
        logic [TEXT_W-1:0] text_4;
        logic [TEXT_W-1:0] text_5;
        logic [TEXT_W-1:0] text_6;
        logic [TEXT_W-1:0] text_7;
    } out_beat_t;

    // work carried down the conversion pipeline; digit 0 is least significant
    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        digit_vec_t        digits;
        logic [REM_W-1:0]  rem;
    } conv_t;

    // digits = digits * 2 + bit_in in base 36; carry out of a digit depends
    // only on that digit, so all digits update in parallel
    function automatic digit_vec_t b36_double(digit_vec_t d, logic bit_in);
        digit_vec_t           r;
        logic [NUM_DIGITS:0]  carry;
        logic [DIGIT_W:0]     twice;
        carry[0] = bit_in;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            carry[i+1] = (d[i] >= DIGIT_W'(HALF_RADIX));
        end
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            twice = {d[i], carry[i]};
            if (carry[i+1])
            begin
                r[i] = DIGIT_W'(twice - (DIGIT_W+1)'(RADIX));
            end
            else
            begin
                r[i] = twice[DIGIT_W-1:0];
            end
        end
        return r;
    endfunction

    // one pipeline stage worth of conversion steps, msb of rem first
    function automatic conv_t b36_stage_next(conv_t cur);
        conv_t nxt;
        nxt = cur;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            nxt.digits = b36_double(nxt.digits, nxt.rem[REM_W-1]);
            nxt.rem    = {nxt.rem[REM_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // base-36 digit to upper-case ascii
    function automatic logic [TEXT_W-1:0] digit_ascii(digit_t d);
        logic [TEXT_W-1:0] wide;
        wide = {{(TEXT_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(DECIMAL_DIGITS))
        begin
            return TEXT_W'(ASCII_ZERO) + wide;
        end
        return TEXT_W'(ASCII_ALPHA_OFS) + wide;
    endfunction

endpackage

/* rtl/core/dph_accum.sv */
// string accumulators (seed 31 and seed 131) and the launch register of the hash
// depends on dph_pkg and the core assertion macro header
`include "dual_polynomial_string_hash_core_defines.svh"

module dph_accum
    import dph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_data,
    output logic     launch_valid,
    input  logic     launch_ready,
    output conv_t    launch_data
);

    logic [ACC_W-1:0]   acc31_reg;
    logic [ACC_W-1:0]   acc131_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               launch_valid_reg;
    conv_t              launch_data_reg;

    logic [ACC_W-1:0]   acc31_next;
    logic [ACC_W-1:0]   acc131_next;
    logic [COUNT_W-1:0] count_next;
    logic [ACC_W-1:0]   char_ext;
    logic               take_char;
    logic               accept;
    logic [HASH_W-1:0]  hash_next;
    conv_t              launch_data_next;

    // beat handshake: a launch slot must be free or draining
    assign in_ready = !launch_valid_reg || launch_ready;
    assign accept   = in_valid && in_ready;

    // character update, limited to the first MAX_CHARS characters
    always_comb
    begin
        char_ext  = {{(ACC_W-CHAR_W){1'b0}}, in_data.char_code};
        take_char = in_data.has_char && (count_reg < COUNT_W'(MAX_CHARS));
        if (take_char)
        begin
            acc31_next  = (acc31_reg << 5) - acc31_reg + char_ext;
            acc131_next = (acc131_reg << 7) + (acc131_reg << 1) + acc131_reg + char_ext;
            count_next  = count_reg + COUNT_W'(1);
        end
        else
        begin
            acc31_next  = acc31_reg;
            acc131_next = acc131_reg;
            count_next  = count_reg;
        end
    end

    // combined hash and initial conversion word
    always_comb
    begin
        hash_next                   = {acc31_next, acc131_next[ACC_W-1:TOP_SHIFT]};
        launch_data_next.hash_value = hash_next;
        launch_data_next.digits     = '0;
        launch_data_next.rem        = {{(REM_W-HASH_W){1'b0}}, hash_next};
    end

    // accumulator state, cleared at the end of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc31_reg        <= '0;
            acc131_reg       <= '0;
            count_reg        <= '0;
            launch_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (in_data.last)
                begin
                    acc31_reg  <= '0;
                    acc131_reg <= '0;
                    count_reg  <= '0;
                end
                else
                begin
                    acc31_reg  <= acc31_next;
                    acc131_reg <= acc131_next;
                    count_reg  <= count_next;
                end
            end
            if (accept && in_data.last)
            begin
                launch_valid_reg <= 1'b1;
            end
            else if (launch_ready)
            begin
                launch_valid_reg <= 1'b0;
            end
        end
    end

    // launch payload
    always_ff @(posedge clk)
    begin
        if (accept && in_data.last)
        begin
            launch_data_reg <= launch_data_next;
        end
    end

    assign launch_valid = launch_valid_reg;
    assign launch_data  = launch_data_reg;

    // checks
    `DPH_ASSERT_NEXT(a_clear_after_last, clk, rst_n, accept && in_data.last, acc31_reg == '0 && acc131_reg == '0 && count_reg == '0)
    `DPH_ASSERT_IMPLY(a_count_limit, clk, rst_n, 1'b1, count_reg <= COUNT_W'(MAX_CHARS))
    `DPH_ASSERT_NEXT(a_no_launch_mid_string, clk, rst_n, accept && !in_data.last && !launch_valid_reg, !launch_valid_reg)

endmodule

/* rtl/core/dph_b36_stage.sv */
// one stage of the base-36 shift-and-double conversion pipeline
// depends on dph_pkg (conv_t and b36_stage_next)
module dph_b36_stage
    import dph_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  conv_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output conv_t out_data
);

    logic  valid_reg;
    conv_t data_reg;
    conv_t data_next;
    logic  accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign data_next = b36_stage_next(in_data);

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/dph_out_reg.sv */
// result register: turns base-36 digits into ascii text next to the hash value
// depends on dph_pkg (conv_t, out_beat_t, digit_ascii)
module dph_out_reg
    import dph_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  conv_t     in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      valid_reg;
    out_beat_t data_reg;
    out_beat_t data_next;
    logic      accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // digit 7 is the most significant and leads the text
    always_comb
    begin
        data_next.hash_value = in_data.hash_value;
        data_next.text_0     = digit_ascii(in_data.digits[7]);
        data_next.text_1     = digit_ascii(in_data.digits[6]);
        data_next.text_2     = digit_ascii(in_data.digits[5]);
        data_next.text_3     = digit_ascii(in_data.digits[4]);
        data_next.text_4     = digit_ascii(in_data.digits[3]);
        data_next.text_5     = digit_ascii(in_data.digits[2]);
        data_next.text_6     = digit_ascii(in_data.digits[1]);
        data_next.text_7     = digit_ascii(in_data.digits[0]);
    end

    // result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/dual_polynomial_string_hash_core.sv */
// Dual polynomial string hash core.
// Input channel (in_valid/in_ready/in_data): one 16-bit character per beat, has_char
// flags a real character, last closes the string. Only the first 128 characters of a
// string enter the two 32-bit accumulators (x31 and x131, modulo 2^32).
// Output channel (out_valid/out_ready/out_data): one beat per string, carrying the
// 41-bit hash (seed-31 hash << 9 | bits 31..23 of the seed-131 hash) and the same value
// as eight zero-padded upper-case base-36 ascii digits, most significant first.
// Throughput: one input beat per cycle while in_ready is high. The hash of a last beat
// passes through one launch register, six conversion stages of seven shift-and-double
// steps each, then the result register, which drives out_valid.
// Strings may follow each other back to back; up to eight finished hashes sit in the
// pipeline at once. When the receiver holds out_ready low the pipeline fills up and
// in_ready falls once the launch register cannot move on.
// Reset clears the accumulators and all stage valid bits; no result is pending after it.
// depends on dph_pkg, dph_accum, dph_b36_stage and dph_out_reg
module dual_polynomial_string_hash_core
    import dph_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic  stage_valid [0:NUM_STAGES];
    logic  stage_ready [0:NUM_STAGES];
    conv_t stage_data  [0:NUM_STAGES];

    // accumulators and launch register
    dph_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .launch_valid (stage_valid[0]),
        .launch_ready (stage_ready[0]),
        .launch_data  (stage_data[0])
    );

    // base-36 conversion pipeline
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_conv
        dph_b36_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // ascii formatting and result register
    dph_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NUM_STAGES]),
        .in_ready  (stage_ready[NUM_STAGES]),
        .in_data   (stage_data[NUM_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* verif/tb.sv */
// self-checking testbench for dual_polynomial_string_hash_core: strings of wide characters
// go in, each hash and its base-36 text is checked against a predictor kept in the bench
// depends on dph_pkg and the core rtl
module tb
    import dph_pkg::*;
;

    localparam logic [ACC_W-1:0] SEED_A     = 32'd31;
    localparam logic [ACC_W-1:0] SEED_B     = 32'd131;
    localparam int               GAP_MAX    = 16;
    localparam int               HOLD_LEN   = 600;
    localparam int               ITEM_GOAL  = 1250;
    localparam int               DRAIN_WAIT = 24;
    localparam int               PRINT_CAP  = 40;

    // predicts the hash of each string and checks every result beat against it
    class string_hash_checker;
        logic [ACC_W-1:0] acc_a;
        logic [ACC_W-1:0] acc_b;
        int               chars_in;
        out_beat_t        expected_hashes[$];
        int               errors;
        int               checked;

        function new();
            acc_a    = '0;
            acc_b    = '0;
            chars_in = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("tb: mismatch %0d: %s", errors, what);
        endtask

        // fold one accepted input beat into the accumulators
        function void note_beat(in_beat_t b);
            out_beat_t         r;
            logic [HASH_W-1:0] rest;
            int                dig;
            logic [TEXT_W-1:0] ch;
            if (b.has_char && chars_in < MAX_CHARS)
            begin
                acc_a    = acc_a * SEED_A + ACC_W'(b.char_code);
                acc_b    = acc_b * SEED_B + ACC_W'(b.char_code);
                chars_in = chars_in + 1;
            end
            if (b.last)
            begin
                r            = '0;
                r.hash_value = {acc_a, acc_b[ACC_W-1:TOP_SHIFT]};
                rest         = r.hash_value;
                // digits from least significant up, text_0 ends up most significant
                for (int k = NUM_DIGITS - 1; k >= 0; k--)
                begin
                    dig  = int'(rest % RADIX);
                    rest = rest / RADIX;
                    ch   = (dig < DECIMAL_DIGITS) ? TEXT_W'(dig + ASCII_ZERO)
                                                  : TEXT_W'(dig + ASCII_ALPHA_OFS);
                    r[(NUM_DIGITS - 1 - k) * TEXT_W +: TEXT_W] = ch;
                end
                expected_hashes = {expected_hashes, r};
                acc_a    = '0;
                acc_b    = '0;
                chars_in = 0;
            end
        endfunction

        // compare one result beat with the oldest prediction
        task check_result(out_beat_t got);
            out_beat_t         want;
            logic [TEXT_W-1:0] g;
            logic [TEXT_W-1:0] w;
            if (expected_hashes.size() == 0)
            begin
                report($sformatf("result with nothing pending, hash %h", got.hash_value));
                return;
            end
            want = expected_hashes.pop_front();
            checked++;
            if (got.hash_value !== want.hash_value)
                report($sformatf("hash %h, expected %h", got.hash_value, want.hash_value));
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                g = got[(NUM_DIGITS - 1 - k) * TEXT_W +: TEXT_W];
                w = want[(NUM_DIGITS - 1 - k) * TEXT_W +: TEXT_W];
                if (g !== w)
                    report($sformatf("text_%0d %h, expected %h (hash %h)", k, g, w,
                                     want.hash_value));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    string_hash_checker sb;

    int items_sent;
    int strings_sent;
    int empty_strings;
    int over_limit;
    int input_stalls;
    bit recv_holding = 1'b0;

    dual_polynomial_string_hash_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // count cycles where the core pushes back on the input
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            input_stalls++;
    end

    // offer one beat after an idle gap, return once it is accepted
    task send_beat(in_beat_t b, int gap_max);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(b);
        items_sent++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return CHAR_W'($urandom_range(32, 126));
            default: return CHAR_W'($urandom);
        endcase
    endfunction

    // one string of len characters with random content, empty beats sprinkled in
    task send_string(int len, int gap_max);
        in_beat_t b;
        bit       split_last;
        split_last = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                b = '{char_code: CHAR_W'($urandom), has_char: 1'b0, last: 1'b0};
                send_beat(b, gap_max);
            end
            b = '{char_code: pick_char(), has_char: 1'b1,
                  last: (!split_last && i == len - 1)};
            send_beat(b, gap_max);
        end
        if (split_last)
        begin
            b = '{char_code: CHAR_W'($urandom), has_char: 1'b0, last: 1'b1};
            send_beat(b, gap_max);
        end
        strings_sent++;
        if (len == 0)
            empty_strings++;
        if (len > MAX_CHARS)
            over_limit++;
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 12);
        if (sel < 85)
            return $urandom_range(0, 3);
        if (sel < 95)
            return $urandom_range(13, 60);
        return $urandom_range(MAX_CHARS - 8, MAX_CHARS + 12);
    endfunction

    // result side: random ready gaps, two long holds to back the core up
    initial
    begin
        int results;
        int gap;
        int gap_max;
        results = 0;
        gap_max = GAP_MAX;
        @(posedge rst_n);
        forever
        begin
            if (results % 32 == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            if (results == 12 || results == 60)
            begin
                recv_holding = 1'b1;
                gap          = HOLD_LEN;
            end
            else
            begin
                gap = $urandom_range(0, gap_max);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            recv_holding = 1'b0;
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
            results++;
        end
    end

    // reset, directed strings, random strings, drain and verdict
    initial
    begin
        in_beat_t b;
        int       len;
        int       gap_max;
        sb           = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_beat('{char_code: 16'hFFFF, has_char: 1'b0, last: 1'b1}, GAP_MAX);
        // single extreme character carried on the last beat
        send_beat('{char_code: 16'hFFFF, has_char: 1'b1, last: 1'b1}, GAP_MAX);
        send_beat('{char_code: 16'h0000, has_char: 1'b1, last: 1'b1}, GAP_MAX);
        // zero character counts, then an empty beat closes the string
        send_beat('{char_code: 16'h0000, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'hA5A5, has_char: 1'b0, last: 1'b1}, GAP_MAX);
        // mixed string with an ignored empty beat in the middle
        send_beat('{char_code: 16'h0001, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h8000, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h5A5A, has_char: 1'b0, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h7FFF, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h0001, has_char: 1'b1, last: 1'b1}, GAP_MAX);
        // all-ones run to push the accumulators high
        repeat (6) send_beat('{char_code: 16'hFFFF, has_char: 1'b1, last: 1'b0}, 0);
        send_beat('{char_code: 16'h0000, has_char: 1'b1, last: 1'b1}, 0);
        // printable text
        send_beat('{char_code: 16'h0041, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h007A, has_char: 1'b1, last: 1'b0}, GAP_MAX);
        send_beat('{char_code: 16'h0030, has_char: 1'b1, last: 1'b1}, GAP_MAX);
        strings_sent = 7;
        empty_strings = 1;

        // strings at and past the character limit
        send_string(MAX_CHARS, 0);
        send_string(MAX_CHARS + 1, 2);
        send_string(MAX_CHARS + 12, GAP_MAX);

        // random strings; short back-to-back strings while the receiver holds off
        gap_max = GAP_MAX;
        while (items_sent < ITEM_GOAL)
        begin
            if (recv_holding)
            begin
                send_string($urandom_range(0, 3), 1);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    gap_max = ($urandom_range(0, 1) == 0) ? 0 : GAP_MAX;
                len = pick_length();
                send_string(len, gap_max);
            end
        end
        in_valid <= 1'b0;

        while (sb.expected_hashes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("tb: %0d strings (%0d empty, %0d past the limit), %0d input beats",
                 strings_sent, empty_strings, over_limit, items_sent);
        $display("tb: %0d hashes checked, input held off for %0d cycles",
                 sb.checked, input_stalls);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
